// File: hdl/ffba_pkg.sv
`default_nettype none
package ffba_pkg;
    localparam int Blocks = 1024;
    localparam int IdxW = $clog2(Blocks);
    localparam int CntW = IdxW + 1;

    localparam logic [1:0] StOk         = 2'd0;
    localparam logic [1:0] StNoSpace    = 2'd1;
    localparam logic [1:0] StMisaligned = 2'd2;
    localparam logic [1:0] StOutside    = 2'd3;

    localparam logic [1:0] RegBlockSize  = 2'd0;
    localparam logic [1:0] RegBlockCount = 2'd1;
    localparam logic [1:0] RegRegionBase = 2'd2;

    localparam logic FuncAlloc = 1'b0;
    localparam logic FuncFree  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_AL_CHECK, S_SCAN, S_SCAN_RD, S_MARK,
        S_MUL, S_FR_CHECK, S_FR_RD, S_FR_WALK, S_DONE
    } t_state;

    // Result of the shared divider.
    typedef struct packed {
        logic [31:0] quot;
        logic        rem_zero;
    } t_div_res;
endpackage
`default_nettype wire

// File: hdl/ffba_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module ffba_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [31:0]      i_dividend,
    input  wire logic [16:0]      i_divisor,
    output logic                  o_done,
    output ffba_pkg::t_div_res    o_res
);
    import ffba_pkg::*;

    logic [31:0] r_quot, n_quot;
    logic [17:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [16:0] r_dsr, n_dsr;
    logic [17:0] w_trial;

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_dsr  = r_dsr;
        w_trial = {r_rem[16:0], r_quot[31]};
        if (i_start) begin
            n_quot = i_dividend;
            n_rem  = '0;
            n_cnt  = 6'd0;
            n_busy = 1'b1;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_quot = {r_quot[30:0], 1'b0};
            if (w_trial >= {1'b0, r_dsr}) begin
                n_rem = w_trial - {1'b0, r_dsr};
                n_quot[0] = 1'b1;
            end else begin
                n_rem = w_trial;
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dsr  <= n_dsr;
    end

    assign o_done       = r_busy && (r_cnt == 6'd31) && !i_start;
    assign o_res.quot   = n_quot;
    assign o_res.rem_zero = (n_rem == '0);
endmodule
`default_nettype wire

// File: hdl/first_fit_block_allocator.sv
`default_nettype none
// First-fit block allocator.
// Input channel (i_valid/o_ready) carries one transaction: i_func selects
// allocate (i_request_bytes) or free (i_release_address). Output channel
// (o_valid/i_ready) returns o_granted_address and o_status for each one.
// The configuration port writes block_size, block_count and region_base;
// the user must write them only while the block is idle; it is not enforced.
// Each item first runs the serial divider for the divide by the block size,
// then visits map entries, each with a read and then a test of the
// registered data: an allocate scans up to block_count entries (at most
// 1024) and marks the run one entry per cycle, then a shift-add multiply
// forms the address; a free walks the trailing body entries. A zero-byte
// allocate skips the divider and returns a no-space status.
// After reset a clearing pass empties all 1024 map entries; no item is
// accepted meanwhile. The result is held in an output register until taken;
// while the receiver stalls, no new transaction is accepted.
module first_fit_block_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_func,
    input  wire logic [31:0] i_request_bytes,
    input  wire logic [31:0] i_release_address,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_granted_address,
    output logic [1:0]       o_status
);
    import ffba_pkg::*;

    logic [16:0] r_bsize;
    logic [10:0] r_bcount;
    logic [31:0] r_base;

    logic [1:0]  r_map [Blocks];
    logic [1:0]  r_rd;

    t_state      r_state, n_state;
    logic        r_func;
    logic [CntW-1:0] r_i, n_i;        // scan / walk index
    logic [CntW-1:0] r_run, n_run;
    logic [CntW-1:0] r_start, n_start;
    logic [32:0] r_need, n_need;
    logic [31:0] r_acc, n_acc;        // multiply accumulator
    logic [16:0] r_mcnd, n_mcnd;
    logic [4:0]  r_mbit, n_mbit;
    logic [31:0] r_gaddr, n_gaddr;
    logic [1:0]  r_stat, n_stat;
    logic        r_ovld, n_ovld;

    logic        w_we;
    logic [IdxW-1:0] w_wa;
    logic [1:0]  w_wd;
    logic [IdxW-1:0] w_ra;
    logic        w_dstart;
    logic [31:0] w_dividend;
    logic        w_ddone;
    t_div_res    w_dres;
    logic [16:0] w_bs;
    logic [CntW-1:0] w_cnt;

    assign w_bs  = (r_bsize == '0) ? 17'd1 : r_bsize;
    assign w_cnt = (r_bcount > 11'(Blocks)) ? CntW'(Blocks) : CntW'(r_bcount);

    ffba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dstart),
        .i_dividend (w_dividend),
        .i_divisor  (w_bs),
        .o_done     (w_ddone),
        .o_res      (w_dres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsize  <= 17'd64;
            r_bcount <= 11'd1024;
            r_base   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegBlockSize:  r_bsize  <= i_cfg_data[16:0];
                RegBlockCount: r_bcount <= i_cfg_data[10:0];
                RegRegionBase: r_base   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_map[w_wa] <= w_wd;
        end
        r_rd <= r_map[w_ra];
    end

    assign w_dividend = (i_func == FuncAlloc) ? i_request_bytes - 32'd1
                                              : i_release_address - r_base;

    always_comb begin
        n_state = r_state;
        n_i = r_i; n_run = r_run; n_start = r_start; n_need = r_need;
        n_acc = r_acc; n_mcnd = r_mcnd; n_mbit = r_mbit;
        n_gaddr = r_gaddr; n_stat = r_stat; n_ovld = r_ovld;
        w_we = 1'b0; w_wa = r_i[IdxW-1:0]; w_wd = 2'b00;
        w_ra = r_i[IdxW-1:0];
        w_dstart = 1'b0;
        o_ready = 1'b0;
        if (r_ovld && i_ready) begin
            n_ovld = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                n_i = r_i + 1'b1;
                if (r_i == CntW'(Blocks - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = !r_ovld;
                if (i_valid && !r_ovld) begin
                    n_gaddr = '0;
                    n_stat = StOk;
                    if (i_func == FuncAlloc && i_request_bytes == '0) begin
                        n_stat = StNoSpace;
                        n_state = S_DONE;
                    end else begin
                        w_dstart = 1'b1;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_ddone) begin
                    n_need = {1'b0, w_dres.quot} + 33'd1;
                    n_state = (r_func == FuncAlloc) ? S_AL_CHECK : S_FR_CHECK;
                    if (r_func == FuncFree && !w_dres.rem_zero) begin
                        n_stat = StMisaligned;
                        n_state = S_DONE;
                    end else if (r_func == FuncFree) begin
                        n_need = {1'b0, w_dres.quot};
                    end
                end
            end
            S_AL_CHECK: begin
                n_i = '0; n_run = '0; n_start = '0;
                if (r_need > {22'd0, w_cnt}) begin
                    n_stat = StNoSpace;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                // Read issued at r_i; data arrives next cycle.
                if (r_i >= w_cnt) begin
                    n_stat = StNoSpace;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rd[0]) begin
                    n_run = '0;
                    n_i = r_i + 1'b1;
                    n_state = S_SCAN_RD;
                end else begin
                    if (r_run == '0) begin
                        n_start = r_i;
                    end
                    n_run = r_run + 1'b1;
                    if ({22'd0, r_run} + 33'd1 == r_need) begin
                        n_i = (r_run == '0) ? r_i : r_start;
                        n_state = S_MARK;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_MARK: begin
                w_we = 1'b1;
                w_wd = (r_i == r_start) ? 2'b11 : 2'b01;
                n_i = r_i + 1'b1;
                if ({22'd0, r_i} == {22'd0, r_start} + r_need - 33'd1) begin
                    n_acc = r_base;
                    n_mcnd = w_bs;
                    n_mbit = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // Shift-add: one bit of the block size per cycle.
                if (r_mcnd[0]) begin
                    n_acc = r_acc + (32'(r_start) << r_mbit);
                end
                n_mcnd = r_mcnd >> 1;
                n_mbit = r_mbit + 5'd1;
                if (r_mbit == 5'd16) begin
                    n_state = S_DONE;
                end
            end
            S_FR_CHECK: begin
                if (r_need >= {22'd0, w_cnt}) begin
                    n_stat = StOutside;
                    n_state = S_DONE;
                end else begin
                    w_we = 1'b1;
                    w_wa = r_need[IdxW-1:0];
                    n_i = r_need[CntW-1:0] + 1'b1;
                    n_state = S_FR_RD;
                end
            end
            S_FR_RD: begin
                if (r_i >= w_cnt) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FR_WALK;
                end
            end
            S_FR_WALK: begin
                if (!r_rd[0] || r_rd[1]) begin
                    n_state = S_DONE;
                end else begin
                    w_we = 1'b1;
                    n_i = r_i + 1'b1;
                    n_state = S_FR_RD;
                end
            end
            S_DONE: begin
                if (r_stat == StOk && r_func == FuncAlloc) begin
                    n_gaddr = r_acc;
                end
                n_ovld = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_i     <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_ovld  <= n_ovld;
        end
        if (o_ready && i_valid) begin
            r_func  <= i_func;
        end
        r_run <= n_run; r_start <= n_start; r_need <= n_need;
        r_acc <= n_acc; r_mcnd <= n_mcnd; r_mbit <= n_mbit;
        r_gaddr <= n_gaddr; r_stat <= n_stat;
    end

    assign o_valid = r_ovld;
    assign o_granted_address = r_gaddr;
    assign o_status = r_stat;

    // A granted address only comes with an ok status.
    a_gaddr_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != StOk) |-> (o_granted_address == '0))
        else $error("granted address without ok status");
    // No transaction is taken while a result waits.
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("ready while result pending");
    // A held result stays until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status)))
        else $error("result dropped");
    // The map is only written by the sequencer outside idle.
    a_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("map written while idle");
endmodule
`default_nettype wire
